// File: hdl/lst_pkg.sv
// Shared types, widths and token kind codes for the Lox source tokenizer.
// No dependencies.
package lst_pkg;

    localparam int POS_W  = 20;
    localparam int LINE_W = 16;
    localparam int KIND_W = 6;

    localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};
    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

    localparam logic [KIND_W-1:0] K_ERROR  = 6'd0;
    localparam logic [KIND_W-1:0] K_STRING = 6'd1;
    localparam logic [KIND_W-1:0] K_NUMBER = 6'd2;
    localparam logic [KIND_W-1:0] K_IDENT  = 6'd3;
    localparam logic [KIND_W-1:0] K_EOF    = 6'd20;
    localparam logic [KIND_W-1:0] K_LPAREN = 6'd21;
    localparam logic [KIND_W-1:0] K_RPAREN = 6'd22;
    localparam logic [KIND_W-1:0] K_LBRACE = 6'd23;
    localparam logic [KIND_W-1:0] K_RBRACE = 6'd24;
    localparam logic [KIND_W-1:0] K_SEMI   = 6'd25;
    localparam logic [KIND_W-1:0] K_COMMA  = 6'd26;
    localparam logic [KIND_W-1:0] K_DOT    = 6'd27;
    localparam logic [KIND_W-1:0] K_MINUS  = 6'd28;
    localparam logic [KIND_W-1:0] K_PLUS   = 6'd29;
    localparam logic [KIND_W-1:0] K_SLASH  = 6'd30;
    localparam logic [KIND_W-1:0] K_STAR   = 6'd31;
    localparam logic [KIND_W-1:0] K_BANG_EQ = 6'd32;
    localparam logic [KIND_W-1:0] K_BANG   = 6'd33;
    localparam logic [KIND_W-1:0] K_EQ_EQ  = 6'd34;
    localparam logic [KIND_W-1:0] K_EQ     = 6'd35;
    localparam logic [KIND_W-1:0] K_LESS_EQ = 6'd36;
    localparam logic [KIND_W-1:0] K_LESS   = 6'd37;
    localparam logic [KIND_W-1:0] K_GREATER_EQ = 6'd38;
    localparam logic [KIND_W-1:0] K_GREATER = 6'd39;

    localparam logic [POS_W-1:0] MSG_UNTERM_LEN = 20'd20;
    localparam logic [POS_W-1:0] MSG_UNEXP_LEN  = 20'd21;

    localparam int NUM_KW = 16;

    typedef logic [47:0] t_kw_word;

    // keyword text left aligned, first byte in the top byte
    localparam t_kw_word KW_WORD [NUM_KW] = '{
        {"and",    24'h0}, {"class",  8'h0}, {"else",   16'h0}, {"false",  8'h0},
        {"for",    24'h0}, {"fun",    24'h0}, {"if",     32'h0}, {"nil",    24'h0},
        {"or",     32'h0}, {"print",  8'h0}, {"return"},        {"super",  8'h0},
        {"var",    24'h0}, {"while",  8'h0}, {"this",   16'h0}, {"true",   16'h0}
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
        3'd2, 3'd5, 3'd6, 3'd5, 3'd3, 3'd5, 3'd4, 3'd4
    };

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_source;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] token_kind;
        logic [POS_W-1:0]  token_start;
        logic [POS_W-1:0]  token_length;
        logic [LINE_W-1:0] line_number;
        logic              last_token;
    } t_out_item;

    typedef struct packed {
        t_out_item [2:0] tok;
        logic [1:0]      cnt;
    } t_tok_group;

    // buf holds the identifier's first six bytes, first byte on top
    function automatic logic [KIND_W-1:0] kw_kind(input t_kw_word buf_w,
                                                  input logic [POS_W-1:0] len);
        logic [KIND_W-1:0] kind;
        t_kw_word          mask;
        kind = K_IDENT;
        for (int i = NUM_KW - 1; i >= 0; i--) begin
            mask = ~({48{1'b1}} >> (8 * KW_LEN[i]));
            if (len == POS_W'(KW_LEN[i]) && ((buf_w ^ KW_WORD[i]) & mask) == '0) begin
                kind = KIND_W'(4 + i);
            end
        end
        return kind;
    endfunction

endpackage

// File: hdl/lst_scan.sv
// Scanner state and per-byte token logic: builds up to three tokens per item.
// Depends on lst_pkg.
module lst_scan import lst_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_in_item   i_item,
    output t_tok_group o_group
);

    localparam logic [3:0] M_IDLE     = 4'd0;
    localparam logic [3:0] M_SLASH    = 4'd1;
    localparam logic [3:0] M_COMMENT  = 4'd2;
    localparam logic [3:0] M_IDENT    = 4'd3;
    localparam logic [3:0] M_NUMBER   = 4'd4;
    localparam logic [3:0] M_NUMDOT   = 4'd5;
    localparam logic [3:0] M_FRACTION = 4'd6;
    localparam logic [3:0] M_STRING   = 4'd7;
    localparam logic [3:0] M_OPERATOR = 4'd8;

    logic [3:0]        r_mode, n_mode;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_lex, n_lex;
    logic [LINE_W-1:0] r_line, n_line;
    logic [7:0]        r_op, n_op;
    logic [7:0]        r_kb [6];

    logic              kb_we;
    logic [2:0]        kb_idx;
    logic [7:0]        c;
    logic [POS_W-1:0]  p, nx, idx, dot;
    logic              again;
    logic [KIND_W-1:0] single;
    t_out_item [2:0]   toks;
    logic [1:0]        cnt;
    logic [LINE_W-1:0] line_up;

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic logic [POS_W-1:0] span(input logic [POS_W-1:0] a,
                                              input logic [POS_W-1:0] b);
        return (b >= a) ? b - a : '0;
    endfunction

    function automatic logic [KIND_W-1:0] op_kind(input logic [7:0] op, input logic eq);
        logic [KIND_W-1:0] k;
        case (op)
            "!":     k = eq ? K_BANG_EQ : K_BANG;
            "=":     k = eq ? K_EQ_EQ : K_EQ;
            "<":     k = eq ? K_LESS_EQ : K_LESS;
            default: k = eq ? K_GREATER_EQ : K_GREATER;
        endcase
        return k;
    endfunction

    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_lex   = r_lex;
        n_line  = r_line;
        n_op    = r_op;
        kb_we   = 1'b0;
        kb_idx  = '0;
        toks    = '0;
        cnt     = '0;
        again   = 1'b0;
        single  = '0;
        c       = i_item.source_byte;
        p       = r_pos;
        nx      = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
        idx     = r_pos - r_lex;
        dot     = (r_pos > r_lex) ? r_pos - 1'b1 : r_lex;
        line_up = (r_line == LINE_MAX) ? r_line : r_line + 1'b1;
        if (i_accept) begin
            if (i_item.end_of_source) begin
                unique case (r_mode)
                    M_SLASH: begin
                        toks[cnt] = '{K_SLASH, r_lex, span(r_lex, p), r_line, 1'b0};
                        cnt = cnt + 1'b1;
                    end
                    M_IDENT: begin
                        toks[cnt] = '{kw_kind({r_kb[0], r_kb[1], r_kb[2], r_kb[3], r_kb[4],
                                      r_kb[5]}, idx), r_lex, span(r_lex, p), r_line, 1'b0};
                        cnt = cnt + 1'b1;
                    end
                    M_NUMBER, M_FRACTION: begin
                        toks[cnt] = '{K_NUMBER, r_lex, span(r_lex, p), r_line, 1'b0};
                        cnt = cnt + 1'b1;
                    end
                    M_NUMDOT: begin
                        toks[cnt] = '{K_NUMBER, r_lex, span(r_lex, dot), r_line, 1'b0};
                        cnt = cnt + 1'b1;
                        toks[cnt] = '{K_DOT, dot, span(dot, p), r_line, 1'b0};
                        cnt = cnt + 1'b1;
                    end
                    M_STRING: begin
                        toks[cnt] = '{K_ERROR, p, MSG_UNTERM_LEN, r_line, 1'b0};
                        cnt = cnt + 1'b1;
                    end
                    M_OPERATOR: begin
                        toks[cnt] = '{op_kind(r_op, 1'b0), r_lex, span(r_lex, p), r_line, 1'b0};
                        cnt = cnt + 1'b1;
                    end
                    default: begin
                    end
                endcase
                toks[cnt] = '{K_EOF, p, '0, r_line, 1'b0};
                cnt = cnt + 1'b1;
                n_mode = M_IDLE;
            end else begin
                unique case (r_mode)
                    M_SLASH: begin
                        if (c == "/") begin
                            n_mode = M_COMMENT;
                        end else begin
                            toks[cnt] = '{K_SLASH, r_lex, span(r_lex, p), r_line, 1'b0};
                            cnt = cnt + 1'b1;
                            again = 1'b1;
                        end
                    end
                    M_COMMENT: begin
                        again = (c == "\n");
                    end
                    M_IDENT: begin
                        if (is_alpha(c) || is_digit(c)) begin
                            if (idx < POS_W'(6)) begin
                                kb_we  = 1'b1;
                                kb_idx = idx[2:0];
                            end
                        end else begin
                            toks[cnt] = '{kw_kind({r_kb[0], r_kb[1], r_kb[2], r_kb[3], r_kb[4],
                                          r_kb[5]}, idx), r_lex, span(r_lex, p), r_line, 1'b0};
                            cnt = cnt + 1'b1;
                            again = 1'b1;
                        end
                    end
                    M_NUMBER: begin
                        if (c == ".") begin
                            n_mode = M_NUMDOT;
                        end else if (!is_digit(c)) begin
                            toks[cnt] = '{K_NUMBER, r_lex, span(r_lex, p), r_line, 1'b0};
                            cnt = cnt + 1'b1;
                            again = 1'b1;
                        end
                    end
                    M_NUMDOT: begin
                        if (is_digit(c)) begin
                            n_mode = M_FRACTION;
                        end else begin
                            toks[cnt] = '{K_NUMBER, r_lex, span(r_lex, dot), r_line, 1'b0};
                            cnt = cnt + 1'b1;
                            toks[cnt] = '{K_DOT, dot, span(dot, p), r_line, 1'b0};
                            cnt = cnt + 1'b1;
                            again = 1'b1;
                        end
                    end
                    M_FRACTION: begin
                        if (!is_digit(c)) begin
                            toks[cnt] = '{K_NUMBER, r_lex, span(r_lex, p), r_line, 1'b0};
                            cnt = cnt + 1'b1;
                            again = 1'b1;
                        end
                    end
                    M_STRING: begin
                        if (c == "\"") begin
                            toks[cnt] = '{K_STRING, r_lex, span(r_lex, nx), r_line, 1'b0};
                            cnt = cnt + 1'b1;
                            n_mode = M_IDLE;
                        end else if (c == "\n") begin
                            n_line = line_up;
                        end
                    end
                    M_OPERATOR: begin
                        if (c == "=") begin
                            toks[cnt] = '{op_kind(r_op, 1'b1), r_lex, span(r_lex, nx),
                                          r_line, 1'b0};
                            cnt = cnt + 1'b1;
                            n_mode = M_IDLE;
                        end else begin
                            toks[cnt] = '{op_kind(r_op, 1'b0), r_lex, span(r_lex, p),
                                          r_line, 1'b0};
                            cnt = cnt + 1'b1;
                            again = 1'b1;
                        end
                    end
                    default: begin
                        again = 1'b1;
                    end
                endcase
                if (again) begin
                    n_mode = M_IDLE;
                    if (c == " " || c == "\r" || c == "\t") begin
                    end else if (c == "\n") begin
                        n_line = line_up;
                    end else begin
                        n_lex = p;
                        if (is_alpha(c)) begin
                            kb_we  = 1'b1;
                            kb_idx = '0;
                            n_mode = M_IDENT;
                        end else if (is_digit(c)) begin
                            n_mode = M_NUMBER;
                        end else begin
                            case (c)
                                "/":  n_mode = M_SLASH;
                                "\"": n_mode = M_STRING;
                                "!", "=", "<", ">": begin
                                    n_op   = c;
                                    n_mode = M_OPERATOR;
                                end
                                "(":  single = K_LPAREN;
                                ")":  single = K_RPAREN;
                                "{":  single = K_LBRACE;
                                "}":  single = K_RBRACE;
                                ";":  single = K_SEMI;
                                ",":  single = K_COMMA;
                                ".":  single = K_DOT;
                                "-":  single = K_MINUS;
                                "+":  single = K_PLUS;
                                "*":  single = K_STAR;
                                default: single = K_ERROR;
                            endcase
                            if (n_mode == M_IDLE) begin
                                if (single != K_ERROR) begin
                                    toks[cnt] = '{single, p, span(p, nx), r_line, 1'b0};
                                end else begin
                                    toks[cnt] = '{K_ERROR, nx, MSG_UNEXP_LEN, r_line, 1'b0};
                                end
                                cnt = cnt + 1'b1;
                            end
                        end
                    end
                end
                n_pos = nx;
            end
            if (cnt != '0) begin
                toks[cnt - 1'b1].last_token = 1'b1;
            end
        end
        o_group.tok = toks;
        o_group.cnt = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_pos  <= '0;
            r_lex  <= '0;
            r_line <= LINE_W'(1);
            r_op   <= '0;
        end else begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_lex  <= n_lex;
            r_line <= n_line;
            r_op   <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (kb_we) begin
            r_kb[kb_idx] <= c;
        end
    end

endmodule

// File: hdl/lox_source_tokenizer.sv
// Top level of the Lox source tokenizer: scanner plus three-entry result buffer.
// Depends on lst_pkg and lst_scan.
//
// Usage:
//   Input channel i_in_valid / o_in_stall carries one source byte per item, or an
//   end-of-source marker. Output channel o_out_valid / i_out_stall carries tokens.
//   An item is scanned in the cycle it is accepted; its tokens (zero to three)
//   land in the result buffer and the first is offered on the next cycle.
//   Tokens leave at one per cycle while the receiver does not stall.
//   Throughput: one item per cycle while each releases at most one token and the
//   receiver does not stall; an item that releases more holds the buffer until its
//   tokens leave, and the next item is taken in the cycle its final token leaves.
//   Blanks and comment bytes release nothing and never hold the input.
//   last_token marks the final token released by an item.
//   When the receiver stalls, the offered token holds and o_in_stall is high
//   while more than one token waits, or while one waits and the receiver stalls.
//   Reset (synchronous, active low) returns the scanner to idle at offset zero,
//   line one, and empties the buffer. No clearing pass is needed.
module lox_source_tokenizer import lst_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_tok_group      group;
    t_out_item [2:0] r_buf;
    logic [1:0]      r_cnt;
    logic [1:0]      r_rd;
    logic            in_take;
    logic            out_take;

    assign o_out_valid = (r_cnt != '0);
    assign out_take    = o_out_valid && !i_out_stall;
    assign o_in_stall  = !((r_cnt == '0) || (r_cnt == 2'd1 && out_take));
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_item  = r_buf[r_rd];

    lst_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_take),
        .i_item   (i_in_item),
        .o_group  (group)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= '0;
        end else if (in_take) begin
            r_cnt <= group.cnt;
            r_rd  <= '0;
        end else if (out_take) begin
            r_cnt <= r_cnt - 1'b1;
            r_rd  <= r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_buf <= group.tok;
        end
    end

    a_last_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.last_token |-> r_cnt == 2'd1)
        else $error("last flag on a token that is not the final one");

    a_final_has_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_cnt == 2'd1 |-> o_out_item.last_token)
        else $error("final token of an item lacks last flag");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.line_number != '0)
        else $error("line number zero");

    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt > 2'd1 |-> o_in_stall)
        else $error("item accepted while buffer still busy");

endmodule
